// File: hw/rtl/imurs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imurs_pkg
// shared constants and a helper function for the imu running statistics block
// ---------------------------------------------------------------------------
package imurs_pkg;
    localparam int SENSOR_GROUPS     = 3;
    localparam int PERIOD_COUNT_BITS = 24;
    localparam int NUM_CH            = (SENSOR_GROUPS >= 3) ? 9 : 6;
    localparam int CH_W              = 4;

    localparam int SUM_W  = 40;
    localparam int SQ_W   = 56;
    localparam int ISUM_W = 32;
    localparam int ISQ_W  = 48;

    // memory word: sum, square sum, lowest, highest
    localparam int WORD_W = SUM_W + SQ_W + 32;
    localparam int MEM_D  = 12;
    localparam int MEM_AW = 4;
    // interval accumulators live at entries 9..11
    localparam logic [MEM_AW-1:0] IADDR0 = 4'd9;

    localparam logic signed [15:0] LOW_RESET  = 16'sd16000;
    localparam logic signed [15:0] HIGH_RESET = -16'sd16000;

    localparam logic [31:0] PERIOD_MAX = (32'd1 << PERIOD_COUNT_BITS) - 32'd1;

    localparam int REG_INTERVAL = 0;
    localparam int REG_FRACTION = 1;

    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    function automatic logic [15:0] full_scale(input logic [1:0] k);
        case (k)
            2'd0:    full_scale = 16'd2000;
            2'd1:    full_scale = 16'd4000;
            2'd2:    full_scale = 16'd6000;
            default: full_scale = 16'd8000;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/imurs_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imurs_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module imurs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/imu_running_stats_autorange_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// imu_running_stats_autorange_core
// running per-channel statistics with accelerometer range selection
// ---------------------------------------------------------------------------
// Samples enter on the s_axis channel (nine 16 bit axes plus period_due in
// tuser). Results leave on m_axis: a range decision at each interval end
// and, when period_due is set there, one statistics transfer per channel.
// tlast marks the final result of a sample. Most samples produce nothing.
// All per-channel state sits in one 12 entry ram, read-modify-written one
// entry at a time by a sequencer; one sample is processed at a time.
// A plain sample reads and updates each channel entry in turn, then the three
// interval entries, then is checked for an interval end before next ready.
// At an interval end each accelerometer axis needs two 56 bit divisions
// (one quotient bit per cycle) and a 32 step square root; each statistics
// channel of a period report needs the same.
// After reset a clearing pass loads reset values into all 12 ram entries;
// no sample is taken meanwhile. When m_axis stalls the sequencer holds
// at the result it is presenting and accepts no new sample.
// ---------------------------------------------------------------------------
module imu_running_stats_autorange_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
    input  wire logic [143:0] s_axis_tdata,
    // period_due
    input  wire logic [0:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // channel, mean_value, spread, lowest, highest, range_code, pad
    output logic [71:0]       m_axis_tdata,
    // kind
    output logic [0:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import imurs_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_UPD, S_IRD, S_IUPD, S_CHK,
        S_ARD, S_AWAIT, S_DIV1, S_DIV2, S_ROOT, S_AFIN,
        S_RANGE, S_ROUT,
        S_PRD, S_PWAIT, S_PDIV1, S_PDIV2, S_PROOT, S_POUT, S_PCLR
    } t_state;

    t_state r_state;
    logic [15:0] r_interval_len;
    logic [7:0]  r_frac;
    logic [15:0] r_icnt;
    logic [31:0] r_pcnt;
    logic [143:0] r_samp;
    logic        r_due;
    logic        r_addp;
    logic [MEM_AW-1:0] r_idx;

    // ram
    logic              m_we;
    logic [MEM_AW-1:0] m_addr;
    logic [WORD_W-1:0] m_wdata, m_rdata;

    imurs_ram #(.WIDTH(WORD_W), .DEPTH(MEM_D)) u_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata)
    );

    logic signed [SUM_W-1:0] rd_sum;
    logic [SQ_W-1:0]         rd_sq;
    logic signed [15:0]      rd_lo, rd_hi;
    assign rd_sum = m_rdata[SUM_W-1:0];
    assign rd_sq  = m_rdata[SUM_W +: SQ_W];
    assign rd_lo  = m_rdata[SUM_W+SQ_W +: 16];
    assign rd_hi  = m_rdata[SUM_W+SQ_W+16 +: 16];

    function automatic logic signed [15:0] s_axis_tdata_hold(input logic [3:0] i);
        s_axis_tdata_hold = r_samp[i*16 +: 16];
    endfunction

    // sample of current channel
    logic [3:0] samp_sel;
    logic signed [15:0] cur_s;
    logic signed [31:0] r_sq;
    assign samp_sel = (r_idx >= IADDR0) ? (r_idx - IADDR0) : r_idx;
    assign cur_s = s_axis_tdata_hold(samp_sel);

    // divide / root shared registers
    logic [SQ_W-1:0]  r_num;      // dividend magnitude / quotient
    logic [SQ_W:0]    r_rem;
    logic [31:0]      r_den;
    logic [5:0]       r_step;
    logic             r_neg;
    logic [SQ_W-1:0]  r_sqv;
    logic signed [15:0] r_lo, r_hi;
    logic [16:0]      r_mean_abs;
    logic signed [15:0] r_mean;
    logic [63:0]      r_rv;       // root operand
    logic [33:0]      r_res;
    logic [63:0]      r_bit;
    logic [23:0]      r_v [3];
    logic [2:0]       r_code;
    logic [1:0]       r_k;

    logic [SQ_W:0] rem_sh;
    assign rem_sh = {r_rem[SQ_W-1:0], r_num[SQ_W-1]};

    // output register
    logic r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign s_axis_tready = (r_state == S_IDLE);

    logic [31:0] msq;
    assign msq = r_mean_abs[15:0] * r_mean_abs[15:0];

    logic [SQ_W-1:0] var_q;
    assign var_q = (r_num > {24'd0, msq}) ? (r_num - {24'd0, msq}) : '0;

    logic [23:0] thr;
    assign thr = 24'(full_scale(r_k)) * 24'(r_frac);

    logic [31:0] div_n;
    assign div_n = (r_state inside {S_DIV1, S_DIV2, S_ARD, S_AWAIT})
                   ? ((r_icnt == 16'd0) ? 32'd1 : {16'd0, r_icnt})
                   : ((r_pcnt == 32'd0) ? 32'd1 : r_pcnt);

    always_comb begin
        m_we    = 1'b0;
        m_addr  = r_idx;
        m_wdata = m_rdata;
        case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_wdata = {HIGH_RESET, LOW_RESET, {SQ_W{1'b0}}, {SUM_W{1'b0}}};
            end
            S_UPD: begin
                m_we = 1'b1;
                m_wdata[SUM_W+SQ_W +: 16]    = (cur_s < rd_lo) ? cur_s : rd_lo;
                m_wdata[SUM_W+SQ_W+16 +: 16] = (cur_s > rd_hi) ? cur_s : rd_hi;
                if (r_addp) begin
                    m_wdata[SUM_W-1:0]   = rd_sum + SUM_W'(cur_s);
                    m_wdata[SUM_W +: SQ_W] = rd_sq + SQ_W'($unsigned(r_sq));
                end
            end
            S_IUPD: begin
                m_we = 1'b1;
                m_wdata[SUM_W-1:0]     = rd_sum + SUM_W'(cur_s);
                m_wdata[SUM_W +: SQ_W] = rd_sq + SQ_W'($unsigned(r_sq));
            end
            S_AFIN: begin
                m_we    = 1'b1;
                m_wdata = '0;
            end
            S_PCLR: begin
                m_we    = 1'b1;
                m_wdata = {HIGH_RESET, LOW_RESET, {SQ_W{1'b0}}, {SUM_W{1'b0}}};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_idx          <= '0;
            r_interval_len <= 16'd50;
            r_frac         <= 8'd205;
            r_icnt         <= '0;
            r_pcnt         <= '0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(REG_INTERVAL)) begin
                    r_interval_len <= i_cfg_wdata;
                end else begin
                    r_frac <= i_cfg_wdata[7:0];
                end
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_sq <= cur_s * cur_s;
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == 4'(IADDR0 + 2)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_samp  <= s_axis_tdata;
                        r_due   <= s_axis_tuser[0];
                        r_addp  <= (r_pcnt < PERIOD_MAX);
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    if (r_idx == 4'(NUM_CH - 1)) begin
                        r_idx   <= IADDR0;
                        r_state <= S_IRD;
                        if (r_addp) r_pcnt <= r_pcnt + 32'd1;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_IRD: r_state <= S_IUPD;
                S_IUPD: begin
                    if (r_idx == 4'(IADDR0 + 2)) begin
                        r_icnt  <= r_icnt + 16'd1;
                        r_state <= S_CHK;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_IRD;
                    end
                end
                S_CHK: begin
                    if (r_icnt >= r_interval_len || r_icnt == 16'd0) begin
                        r_idx   <= IADDR0;
                        r_state <= S_ARD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_ARD, S_PRD: r_state <= (r_state == S_ARD) ? S_AWAIT : S_PWAIT;
                S_AWAIT, S_PWAIT: begin
                    // start signed sum divide
                    r_sqv  <= rd_sq;
                    r_lo   <= rd_lo;
                    r_hi   <= rd_hi;
                    r_neg  <= rd_sum[SUM_W-1];
                    r_num  <= SQ_W'(rd_sum[SUM_W-1] ? -rd_sum : rd_sum);
                    r_rem  <= '0;
                    r_den  <= div_n;
                    r_step <= '0;
                    r_state <= (r_state == S_AWAIT) ? S_DIV1 : S_PDIV1;
                end
                S_DIV1, S_PDIV1: begin
                    if (rem_sh >= {25'd0, r_den}) begin
                        r_rem <= rem_sh - {25'd0, r_den};
                        r_num <= {r_num[SQ_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_num <= {r_num[SQ_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(SQ_W - 1)) begin
                        r_state <= (r_state == S_DIV1) ? S_DIV2 : S_PDIV2;
                        r_step  <= '0;
                    end
                end
                S_DIV2, S_PDIV2: begin
                    if (r_step == 6'd0) begin
                        // capture mean from quotient, start square sum divide
                        r_mean_abs <= r_num[16:0];
                        r_mean     <= r_neg ? -r_num[15:0] : r_num[15:0];
                        r_num      <= r_sqv;
                        r_rem      <= '0;
                        r_step     <= 6'd1;
                    end else begin
                        if (rem_sh >= {25'd0, r_den}) begin
                            r_rem <= rem_sh - {25'd0, r_den};
                            r_num <= {r_num[SQ_W-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_num <= {r_num[SQ_W-2:0], 1'b0};
                        end
                        r_step <= r_step + 6'd1;
                        if (r_step == 6'(SQ_W)) begin
                            r_step  <= '0;
                            r_state <= (r_state == S_DIV2) ? S_ROOT : S_PROOT;
                        end
                    end
                end
                S_ROOT, S_PROOT: begin
                    if (r_step == 6'd0) begin
                        r_rv   <= 64'(var_q);
                        r_res  <= '0;
                        r_bit  <= 64'd1 << 62;
                        r_step <= 6'd1;
                    end else if (r_bit == 64'd0) begin
                        r_step  <= '0;
                        if (r_state == S_ROOT) begin
                            r_v[2'(r_idx - IADDR0)] <= 24'(r_mean_abs) + 24'(r_res);
                            r_state <= S_AFIN;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_state  <= S_POUT;
                        end
                    end else begin
                        if (r_rv >= 64'(r_res) + r_bit) begin
                            r_rv  <= r_rv - (64'(r_res) + r_bit);
                            r_res <= 34'((64'(r_res) >> 1) + r_bit);
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_AFIN: begin
                    if (r_idx == 4'(IADDR0 + 2)) begin
                        r_k     <= '0;
                        r_code  <= 3'd5;
                        r_state <= S_RANGE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_RANGE: begin
                    if ({r_v[0], 8'd0} < {8'd0, thr} && {r_v[1], 8'd0} < {8'd0, thr}
                        && {r_v[2], 8'd0} < {8'd0, thr}) begin
                        r_code   <= 3'(r_k) + 3'd1;
                        r_ovalid <= 1'b1;
                        r_state  <= S_ROUT;
                    end else if (r_k == 2'd3) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_ROUT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_ROUT: begin
                    if (m_axis_tready) begin
                        r_icnt <= '0;
                        if (r_due) begin
                            r_idx   <= '0;
                            r_state <= S_PRD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_POUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_PCLR;
                    end
                end
                S_PCLR: begin
                    if (r_idx == 4'(NUM_CH - 1)) begin
                        r_pcnt  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic out_stats;
    assign out_stats = (r_state == S_POUT);
    assign m_axis_tuser = out_stats ? KIND_STATS : KIND_RANGE;
    assign m_axis_tlast = out_stats ? (r_idx == 4'(NUM_CH - 1)) : !r_due;
    assign m_axis_tdata = out_stats
        ? {1'b0, 3'd0, r_hi, r_lo, r_res[15:0], r_mean, r_idx}
        : {1'b0, r_code, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0};
endmodule
`default_nettype wire

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for imu_running_stats_autorange_core
// ---------------------------------------------------------------------------
// Nine-axis samples are streamed in with random gaps. Each result is checked
// field by field against an in-bench model of the running statistics and the
// accelerometer range selection. The bench walks through several interval
// lengths and threshold fractions, including zero, the extremes and an
// interval shrunk under a partly filled interval.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import imurs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct {
        logic signed [15:0] axis[9];
        logic               due;
    } imu_sample_t;

    typedef struct {
        logic        kind;
        logic [3:0]  channel;
        logic [15:0] mean_value;
        logic [15:0] spread;
        logic [15:0] lowest;
        logic [15:0] highest;
        logic [2:0]  range_code;
        logic        last;
    } stats_result_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;

    imu_running_stats_autorange_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    imu_sample_t   pend_samples[$];
    stats_result_t exp_results[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            hold_sender = 1'b0;
    bit            calm = 1'b0;
    int            send_gap = 0;
    int            sink_gap = 0;

    // input accepted at the last rising edge
    bit s_axis_tready_q = 1'b0;

    // model state
    int unsigned       interval_len = 50;
    int unsigned       fraction = 205;
    int unsigned       interval_cnt = 0;
    longint unsigned   period_cnt = 0;
    longint            acc_sum[3];
    longint unsigned   acc_sq[3];
    longint            chan_sum[9];
    longint unsigned   chan_sq[9];
    logic signed [15:0] chan_low[9];
    logic signed [15:0] chan_high[9];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (calm || r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mean_and_dev(longint sum, longint unsigned sq,
                                                     longint unsigned n, output longint m);
        longint unsigned msq, q;
        if (n == 0) n = 1;
        m = sum / longint'(n);
        msq = longint'(m * m);
        q = sq / n;
        return int_sqrt(q > msq ? q - msq : 64'd0);
    endfunction

    task automatic clear_period();
        period_cnt = 0;
        for (int c = 0; c < 9; c++) begin
            chan_sum[c] = 0;
            chan_sq[c] = 0;
            chan_low[c] = LOW_RESET;
            chan_high[c] = HIGH_RESET;
        end
    endtask

    task automatic clear_interval();
        interval_cnt = 0;
        for (int a = 0; a < 3; a++) begin
            acc_sum[a] = 0;
            acc_sq[a] = 0;
        end
    endtask

    task automatic predict_sample(imu_sample_t smp);
        bit              add_period;
        longint          s, m;
        longint unsigned d, t, v[3];
        logic [2:0]      code;
        stats_result_t   r;
        add_period = period_cnt < longint'(PERIOD_MAX);
        for (int c = 0; c < NUM_CH; c++) begin
            s = smp.axis[c];
            if (smp.axis[c] > chan_high[c]) chan_high[c] = smp.axis[c];
            if (smp.axis[c] < chan_low[c]) chan_low[c] = smp.axis[c];
            if (add_period) begin
                chan_sum[c] += s;
                chan_sq[c] += longint'(s * s);
            end
        end
        if (add_period) period_cnt++;
        for (int a = 0; a < 3; a++) begin
            s = smp.axis[a];
            acc_sum[a] += s;
            acc_sq[a] += longint'(s * s);
        end
        interval_cnt = (interval_cnt + 1) & 16'hFFFF;
        if (interval_cnt >= interval_len || interval_cnt == 0) begin
            for (int a = 0; a < 3; a++) begin
                d = mean_and_dev(acc_sum[a], acc_sq[a], interval_cnt, m);
                v[a] = (longint'(m < 0 ? -m : m) + d) * 256;
            end
            code = 3'd5;
            for (int k = 3; k >= 0; k--) begin
                t = longint'(full_scale(k[1:0])) * fraction;
                if (v[0] < t && v[1] < t && v[2] < t) code = 3'(k + 1);
            end
            r = '{KIND_RANGE, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, code, !smp.due};
            exp_results.push_back(r);
            clear_interval();
            if (smp.due) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    d = mean_and_dev(chan_sum[c], chan_sq[c], period_cnt, m);
                    r = '{KIND_STATS, 4'(c), 16'(m), 16'(d), chan_low[c], chan_high[c],
                          3'd0, c == NUM_CH - 1};
                    exp_results.push_back(r);
                end
                clear_period();
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        logic         nv;
        logic [143:0] nd;
        imu_sample_t  smp;
        nv = s_axis_tvalid;
        if (!s_axis_tvalid || s_axis_tready_q) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!hold_sender && pend_samples.size() > 0) begin
                smp = pend_samples.pop_front();
                for (int c = 0; c < 9; c++) nd[c*16 +: 16] = smp.axis[c];
                s_axis_tdata <= nd;
                s_axis_tuser <= smp.due;
                nv = 1'b1;
                send_gap = pick_gap();
            end
        end
        s_axis_tvalid <= nv;
        if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            sink_gap = pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        imu_sample_t   smp;
        stats_result_t e;
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            for (int c = 0; c < 9; c++) smp.axis[c] = s_axis_tdata[c*16 +: 16];
            smp.due = s_axis_tuser[0];
            predict_sample(smp);
        end
        if (m_axis_tvalid && m_axis_tready) begin
            if (exp_results.size() == 0) begin
                $display("unexpected result transfer at %0t", $realtime);
                error_count++;
            end else begin
                e = exp_results.pop_front();
                if (m_axis_tuser[0] !== e.kind) report_mismatch("kind", m_axis_tuser, e.kind);
                if (m_axis_tdata[3:0] !== e.channel)
                    report_mismatch("channel", m_axis_tdata[3:0], e.channel);
                if (m_axis_tdata[19:4] !== e.mean_value)
                    report_mismatch("mean", m_axis_tdata[19:4], e.mean_value);
                if (m_axis_tdata[35:20] !== e.spread)
                    report_mismatch("spread", m_axis_tdata[35:20], e.spread);
                if (m_axis_tdata[51:36] !== e.lowest)
                    report_mismatch("lowest", m_axis_tdata[51:36], e.lowest);
                if (m_axis_tdata[67:52] !== e.highest)
                    report_mismatch("highest", m_axis_tdata[67:52], e.highest);
                if (m_axis_tdata[70:68] !== e.range_code)
                    report_mismatch("range_code", m_axis_tdata[70:68], e.range_code);
                if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("imu_running_stats_autorange_core test failed");
            $finish;
        end
    end

    task automatic write_reg(int idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx[0:0];
        i_cfg_wdata <= value[15:0];
        if (idx == REG_INTERVAL) interval_len = value;
        else fraction = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until the last pending sample has been transferred
    task automatic wait_sent();
        wait (pend_samples.size() == 0);
        do @(posedge i_clk); while (s_axis_tvalid);
    endtask

    task automatic drain();
        wait_sent();
        wait (exp_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_sample(logic signed [15:0] acc, bit due);
        imu_sample_t smp;
        for (int c = 0; c < 9; c++) smp.axis[c] = c < 3 ? acc : 16'($urandom);
        smp.due = due;
        pend_samples.push_back(smp);
    endtask

    task automatic add_random(int count);
        imu_sample_t smp;
        int          mag;
        for (int n = 0; n < count; n++) begin
            mag = $urandom_range(0, 4);
            for (int c = 0; c < 9; c++) begin
                case (mag)
                    0: smp.axis[c] = 16'($urandom);
                    1: smp.axis[c] = $signed(16'($urandom_range(0, 1200))) - 16'sd600;
                    2: smp.axis[c] = $signed(16'($urandom_range(0, 9000))) - 16'sd4500;
                    3: smp.axis[c] = $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
                    default: smp.axis[c] = $signed(16'($urandom_range(0, 4000))) + 16'sd1000;
                endcase
            end
            smp.due = $urandom_range(0, 2) == 0;
            pend_samples.push_back(smp);
        end
    endtask

    initial begin
        imu_sample_t smp;
        clear_interval();
        clear_period();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a range result for every sample, codes one through five and the extremes
        write_reg(REG_INTERVAL, 1);
        write_reg(REG_FRACTION, 255);
        add_sample(16'sd500, 1'b0);
        add_sample(16'sd3000, 1'b1);
        add_sample(-16'sd5000, 1'b0);
        add_sample(16'sd7000, 1'b0);
        add_sample(16'sd20000, 1'b1);
        for (int c = 0; c < 9; c++) smp.axis[c] = 16'sh8000;
        smp.due = 1'b1;
        pend_samples.push_back(smp);
        for (int c = 0; c < 9; c++) smp.axis[c] = 16'sh7fff;
        pend_samples.push_back(smp);
        for (int c = 0; c < 9; c++) smp.axis[c] = 16'sh0000;
        smp.due = 1'b0;
        pend_samples.push_back(smp);
        drain();

        // threshold equality at half scale, zero interval length
        write_reg(REG_FRACTION, 128);
        write_reg(REG_INTERVAL, 0);
        add_sample(16'sd1000, 1'b0);
        add_sample(16'sd999, 1'b1);
        add_sample(-16'sd2000, 1'b0);
        drain();

        // long interval, then shrunk under the filled part
        write_reg(REG_INTERVAL, 65535);
        add_sample(16'sd100, 1'b0);
        add_sample(16'sd300, 1'b0);
        add_sample(-16'sd700, 1'b0);
        drain();
        write_reg(REG_INTERVAL, 2);
        add_sample(16'sd50, 1'b1);
        drain();

        write_reg(REG_INTERVAL, 3);
        write_reg(REG_FRACTION, 205);
        calm = 1'b1;
        add_random(25);
        drain();

        calm = 1'b0;
        write_reg(REG_INTERVAL, 1);
        write_reg(REG_FRACTION, 1);
        add_random(20);
        drain();

        write_reg(REG_INTERVAL, 7);
        write_reg(REG_FRACTION, 255);
        add_random(10);
        drain();

        write_reg(REG_INTERVAL, 2);
        write_reg(REG_FRACTION, 160);
        add_random(15);
        wait_sent();
        hold_sender = 1'b1;
        add_random(15);
        wait (exp_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        hold_sender = 1'b0;
        drain();

        write_reg(REG_INTERVAL, 5);
        write_reg(REG_FRACTION, 230);
        add_random(20);
        drain();

        if (error_count == 0) begin
            $display("imu_running_stats_autorange_core test passed");
        end else begin
            $display("imu_running_stats_autorange_core test failed");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/imurs_pkg.sv
hw/rtl/imurs_ram.sv
hw/rtl/imu_running_stats_autorange_core.sv
sim/testbench.sv
